@@ design/rpn_pkg.sv @@
// package of shared constants and types for the rpn stack calculator
package rpn_pkg;

  localparam int unsigned StackDepthDef   = 128;
  localparam int unsigned FractionBitsDef = 16;
  localparam int unsigned MaxFracDigitsDef = 9;

  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChPoint = 8'h2e;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [63:0] PosMax = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NegMin = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    OpAdd,
    OpSub,
    OpMul,
    OpDiv,
    OpConv
  } op_e;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic        start;
    op_e         op;
    logic [63:0] a;
    logic [63:0] b;
    logic [3:0]  digits;
  } alu_req_t;

  // answer of the arithmetic unit
  typedef struct packed {
    logic        done;
    logic [63:0] result;
    logic        sat;
    logic        divz;
  } alu_rsp_t;

  function automatic logic [63:0] pow10(input logic [3:0] n);
    logic [63:0] r;
    case (n)
      4'd0:    r = 64'd1;
      4'd1:    r = 64'd10;
      4'd2:    r = 64'd100;
      4'd3:    r = 64'd1000;
      4'd4:    r = 64'd10000;
      4'd5:    r = 64'd100000;
      4'd6:    r = 64'd1000000;
      4'd7:    r = 64'd10000000;
      4'd8:    r = 64'd100000000;
      4'd9:    r = 64'd1000000000;
      4'd10:   r = 64'd10000000000;
      4'd11:   r = 64'd100000000000;
      4'd12:   r = 64'd1000000000000;
      4'd13:   r = 64'd10000000000000;
      4'd14:   r = 64'd100000000000000;
      default: r = 64'd1000000000000000;
    endcase
    return r;
  endfunction

endpackage

@@ design/rpn_alu.sv @@
// shared iterative arithmetic unit: add, sub, multiply, divide and number conversion
module rpn_alu #(
  parameter int unsigned FractionBits = rpn_pkg::FractionBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpn_pkg::alu_req_t req_i,
  output rpn_pkg::alu_rsp_t rsp_o
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StConvFrac,
    StFinish
  } state_e;

  localparam int unsigned DivSteps = 64 + FractionBits;

  state_e        state_q;
  op_e           op_q;
  logic [6:0]    cnt_q;
  logic [127:0]  acc_q;
  logic [63:0]   mb_q;
  logic [63:0]   mul_a_q;
  logic [64:0]   rem_q;
  logic [127:0]  num_q;
  logic          neg_q;
  logic [63:0]   res_q;
  logic          sat_q;
  logic          divz_q;
  logic          done_q;

  logic [63:0]   mag_a, mag_b;
  logic [63:0]   sum_add, sum_sub;
  logic [64:0]   rem_sh;
  logic [64:0]   rem_sub;
  logic [127:0]  mul_sh;
  logic [127:0]  mul_sum;
  logic [63:0]   conv_val;

  assign mag_a   = req_i.a[63] ? (64'd0 - req_i.a) : req_i.a;
  assign mag_b   = req_i.b[63] ? (64'd0 - req_i.b) : req_i.b;
  assign sum_add = req_i.a + req_i.b;
  assign sum_sub = req_i.a - req_i.b;
  assign rem_sh  = {rem_q[63:0], num_q[127]};
  assign rem_sub = rem_sh - {1'b0, mb_q};
  assign mul_sh  = {acc_q[126:0], 1'b0};
  assign mul_sum = mul_sh + {64'd0, mul_a_q};
  assign conv_val = (acc_q[63:0] << FractionBits) + 64'(num_q[FractionBits-1:0])
                    + (({rem_q[63:0], 1'b0} >= {1'b0, mb_q}) ? 64'd1 : 64'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      op_q    <= OpAdd;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (req_i.start) begin
            op_q   <= req_i.op;
            sat_q  <= 1'b0;
            divz_q <= 1'b0;
            neg_q  <= req_i.a[63] ^ req_i.b[63];
            unique case (req_i.op)
              OpAdd: begin
                if (req_i.a[63] == req_i.b[63] && sum_add[63] != req_i.a[63]) begin
                  res_q <= req_i.a[63] ? NegMin : PosMax;
                  sat_q <= 1'b1;
                end else begin
                  res_q <= sum_add;
                end
                done_q <= 1'b1;
              end
              OpSub: begin
                if (req_i.a[63] != req_i.b[63] && sum_sub[63] != req_i.a[63]) begin
                  res_q <= req_i.a[63] ? NegMin : PosMax;
                  sat_q <= 1'b1;
                end else begin
                  res_q <= sum_sub;
                end
                done_q <= 1'b1;
              end
              OpMul: begin
                mul_a_q <= mag_a;
                mb_q    <= mag_b;
                acc_q   <= '0;
                cnt_q   <= 7'd0;
                state_q <= StMul;
              end
              OpDiv: begin
                if (req_i.b == 64'd0) begin
                  res_q  <= req_i.a[63] ? NegMin : PosMax;
                  divz_q <= 1'b1;
                  done_q <= 1'b1;
                end else begin
                  mb_q    <= mag_b;
                  num_q   <= {mag_a, 64'd0};
                  rem_q   <= '0;
                  acc_q   <= '0;
                  cnt_q   <= 7'd0;
                  state_q <= StDiv;
                end
              end
              default: begin
                // conversion: integer part by long division of mantissa by 10^n
                mb_q    <= pow10(req_i.digits);
                num_q   <= {req_i.a, 64'd0};
                rem_q   <= '0;
                acc_q   <= '0;
                cnt_q   <= 7'd0;
                state_q <= StDiv;
              end
            endcase
          end
        end
        StMul: begin
          acc_q   <= mb_q[6'd63 - cnt_q[5:0]] ? mul_sum : mul_sh;
          cnt_q   <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) state_q <= StFinish;
        end
        StDiv: begin
          num_q <= {num_q[126:0], 1'b0};
          if (rem_sh >= {1'b0, mb_q}) begin
            rem_q <= rem_sub;
            acc_q <= {acc_q[126:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            acc_q <= {acc_q[126:0], 1'b0};
          end
          cnt_q <= cnt_q + 7'd1;
          if (op_q == OpDiv && cnt_q == 7'(DivSteps - 1)) state_q <= StFinish;
          if (op_q == OpConv && cnt_q == 7'd63) begin
            cnt_q   <= 7'd0;
            state_q <= StConvFrac;
          end
        end
        StConvFrac: begin
          // acc holds integer quotient in low 64 bits, rem the remainder
          if (cnt_q < 7'(FractionBits)) begin
            if ({rem_q[63:0], 1'b0} >= {1'b0, mb_q}) begin
              rem_q <= {rem_q[63:0], 1'b0} - {1'b0, mb_q};
              num_q <= {num_q[126:0], 1'b1};
            end else begin
              rem_q <= {rem_q[63:0], 1'b0};
              num_q <= {num_q[126:0], 1'b0};
            end
            cnt_q <= cnt_q + 7'd1;
          end else begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          state_q <= StIdle;
          done_q  <= 1'b1;
          unique case (op_q)
            OpConv: begin
              if (acc_q[63:0] >= (64'd1 << (63 - FractionBits))) begin
                res_q <= PosMax;
                sat_q <= 1'b1;
              end else if (conv_val[63]) begin
                // rounding carried the value past the largest one
                res_q <= PosMax;
                sat_q <= 1'b1;
              end else begin
                res_q <= conv_val;
              end
            end
            default: begin
              logic [127:0] mag;
              mag = (op_q == OpMul) ? (acc_q >> FractionBits) : acc_q;
              if (neg_q) begin
                if (mag[127:64] != 64'd0 || mag[63:0] > NegMin) begin
                  res_q <= NegMin;
                  sat_q <= 1'b1;
                end else begin
                  res_q <= 64'd0 - mag[63:0];
                end
              end else if (mag[127:64] != 64'd0 || mag[63:0] > PosMax) begin
                res_q <= PosMax;
                sat_q <= 1'b1;
              end else begin
                res_q <= mag[63:0];
              end
            end
          endcase
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;
  assign rsp_o.sat    = sat_q;
  assign rsp_o.divz   = divz_q;

endmodule

@@ design/rpn_stack_calculator_core.sv @@
// top level of the rpn stack calculator: character parser, stack and sequencer
//
// channel  dir  tdata                     tuser
// s_axis   in   char_code[7:0]            end_of_input
// m_axis   out  value[63:0]               flags[3:0]
//
// a space, tab, ignored char or digit keeps tready high unless it closes a number
// after an operator tready is low while the operands are popped and the shared
// bit-serial arithmetic unit computes the result
// closing a number keeps tready low during conversion, then its ending char is handled
// tready stays low while the unit works or a result waits unsent
// reset clears stack count, parser state and flags; stack memory is not cleared
module rpn_stack_calculator_core #(
  parameter int unsigned StackDepth   = rpn_pkg::StackDepthDef,
  parameter int unsigned FractionBits = rpn_pkg::FractionBitsDef,
  parameter int unsigned MaxFracDigits = rpn_pkg::MaxFracDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tuser,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // value
  output logic [3:0]  m_axis_tuser    // empty_pop_seen, stack_full_seen, div_zero_seen,
                                      // saturated_seen
);
  import rpn_pkg::*;

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);

  typedef enum logic [3:0] {
    StIdle,
    StConv,
    StConvWait,
    StPopB,
    StPopA,
    StOpWait,
    StEndPop,
    StEndRd,
    StOut
  } state_e;

  state_e          state_q;
  logic [63:0]     mem_q [StackDepth];
  logic [63:0]     rd_q;
  logic [CntW-1:0] cnt_q;
  logic            in_num_q, after_pt_q;
  logic [63:0]     mant_q;
  logic [3:0]      fdig_q;
  logic [3:0]      flags_q;
  logic [7:0]      ch_q;
  logic            end_q;
  op_e             op_q;
  logic [63:0]     a_q, b_q;
  logic            pend_q;
  alu_req_t        req;
  alu_rsp_t        rsp;
  logic            b_valid_q;
  logic [63:0]     out_q;

  logic            acc;
  logic            is_digit, is_op;
  logic [3:0]      dg;
  logic [63:0]     mant_x10;
  logic [63:0]     mant_new;
  logic            mant_ovf;

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign is_digit = s_axis_tdata >= ChZero && s_axis_tdata <= ChNine;
  assign is_op    = s_axis_tdata == ChPlus || s_axis_tdata == ChMinus ||
                    s_axis_tdata == ChStar || s_axis_tdata == ChSlash;
  assign dg       = 4'(s_axis_tdata - ChZero);
  assign mant_x10 = (mant_q << 3) + (mant_q << 1);
  assign mant_new = mant_x10 + 64'(dg);
  // largest mantissa that still takes another digit without passing 2^64-1
  assign mant_ovf = mant_q > ((dg > 4'd5) ? 64'h1999_9999_9999_9998
                                          : 64'h1999_9999_9999_9999);

  alu_req_t req_d;
  rpn_alu #(.FractionBits(FractionBits)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );
  assign req = req_d;

  always_comb begin
    req_d        = '0;
    req_d.op     = op_q;
    req_d.a      = a_q;
    req_d.b      = b_q;
    req_d.digits = fdig_q;
    if (state_q == StConv) begin
      req_d.start = 1'b1;
      req_d.op    = OpConv;
      req_d.a     = mant_q;
    end else if (state_q == StOpWait && !pend_q) begin
      req_d.start = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.done && cnt_q < CntW'(StackDepth)) begin
      mem_q[cnt_q[AddrW-1:0]] <= rsp.result;
    end
    rd_q <= mem_q[AddrW'(cnt_q - CntW'(1))];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      in_num_q   <= 1'b0;
      after_pt_q <= 1'b0;
      mant_q     <= '0;
      fdig_q     <= '0;
      flags_q    <= '0;
      pend_q     <= 1'b0;
      b_valid_q  <= 1'b0;
      end_q      <= 1'b0;
      op_q       <= OpAdd;
    end else begin
      if (rsp.done) begin
        if (cnt_q >= CntW'(StackDepth)) flags_q[1] <= 1'b1;
        else cnt_q <= cnt_q + CntW'(1);
        if (rsp.sat)  flags_q[3] <= 1'b1;
        if (rsp.divz) flags_q[2] <= 1'b1;
      end
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            ch_q  <= s_axis_tdata;
            end_q <= s_axis_tuser;
            if (s_axis_tuser) begin
              state_q <= in_num_q ? StConv : StEndPop;
            end else if (in_num_q && is_digit) begin
              if (!after_pt_q || fdig_q < 4'(MaxFracDigits)) begin
                if (mant_ovf) begin
                  mant_q     <= 64'hffff_ffff_ffff_ffff;
                  flags_q[3] <= 1'b1;
                end else begin
                  mant_q <= mant_new;
                end
                if (after_pt_q) fdig_q <= fdig_q + 4'd1;
              end
            end else if (in_num_q && s_axis_tdata == ChPoint && !after_pt_q) begin
              after_pt_q <= 1'b1;
            end else if (in_num_q) begin
              state_q <= StConv;
            end else if (is_digit) begin
              in_num_q <= 1'b1;
              mant_q   <= 64'(dg);
            end else if (s_axis_tdata == ChPoint) begin
              in_num_q   <= 1'b1;
              after_pt_q <= 1'b1;
            end else if (is_op) begin
              state_q <= StPopB;
            end
          end
        end
        StConv: state_q <= StConvWait;
        StConvWait: begin
          if (rsp.done) begin
            in_num_q   <= 1'b0;
            after_pt_q <= 1'b0;
            mant_q     <= '0;
            fdig_q     <= '0;
            if (end_q) state_q <= StEndPop;
            else if (ch_q >= ChZero && ch_q <= ChNine) begin
              in_num_q <= 1'b1;
              mant_q   <= 64'(ch_q - ChZero);
              state_q  <= StIdle;
            end else if (ch_q == ChPoint) begin
              in_num_q   <= 1'b1;
              after_pt_q <= 1'b1;
              state_q    <= StIdle;
            end else if (ch_q == ChPlus || ch_q == ChMinus ||
                         ch_q == ChStar || ch_q == ChSlash) begin
              state_q <= StPopB;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        StPopB: begin
          // rd_q becomes top of stack next cycle
          unique case (ch_q)
            ChPlus:  op_q <= OpAdd;
            ChMinus: op_q <= OpSub;
            ChStar:  op_q <= OpMul;
            default: op_q <= OpDiv;
          endcase
          b_valid_q <= cnt_q != '0;
          if (cnt_q == '0) flags_q[0] <= 1'b1;
          else cnt_q <= cnt_q - CntW'(1);
          state_q <= StPopA;
        end
        StPopA: begin
          b_q <= b_valid_q ? rd_q : 64'd0;
          b_valid_q <= cnt_q != '0;
          if (cnt_q == '0) flags_q[0] <= 1'b1;
          else cnt_q <= cnt_q - CntW'(1);
          pend_q  <= 1'b0;
          state_q <= StEndRd;
          end_q   <= 1'b0;
        end
        StEndRd: begin
          // wait in this state for the registered read of the second operand
          if (end_q) begin
            out_q   <= b_valid_q ? rd_q : 64'd0;
            state_q <= StOut;
          end else begin
            a_q     <= b_valid_q ? rd_q : 64'd0;
            state_q <= StOpWait;
          end
        end
        StOpWait: begin
          pend_q <= 1'b1;
          if (rsp.done) begin
            pend_q  <= 1'b0;
            state_q <= StIdle;
          end
        end
        StEndPop: begin
          b_valid_q <= cnt_q != '0;
          if (cnt_q == '0) flags_q[0] <= 1'b1;
          else cnt_q <= cnt_q - CntW'(1);
          end_q   <= 1'b1;
          state_q <= StEndRd;
        end
        StOut: begin
          if (m_axis_tready) begin
            state_q    <= StIdle;
            cnt_q      <= '0;
            flags_q    <= '0;
            in_num_q   <= 1'b0;
            after_pt_q <= 1'b0;
            mant_q     <= '0;
            fdig_q     <= '0;
            end_q      <= 1'b0;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = flags_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(StackDepth)) else $error("stack count beyond depth");
  a_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> cnt_q == '0 && flags_q == '0)
    else $error("state not cleared after result");

endmodule

@@ sim/tb_rpn_stack_calculator_core.sv @@
// testbench for the rpn stack calculator core: directed table, random expressions, scoreboard
`timescale 1ns / 100ps

module tb_rpn_stack_calculator_core;
  import rpn_pkg::*;

  localparam int unsigned Depth = StackDepthDef;
  localparam int unsigned FracBits = FractionBitsDef;
  localparam int unsigned MaxDigits = MaxFracDigitsDef;
  localparam int unsigned TotalItems = 1900;

  localparam int FlagEmpty = 0;
  localparam int FlagFull = 1;
  localparam int FlagDivz = 2;
  localparam int FlagSat = 3;

  typedef struct {
    logic [63:0] value;
    logic [3:0]  flags;
  } answer_t;

  typedef struct {
    logic [7:0]  ch;
    logic        eoi;
    bit          typed;
    logic [63:0] value;
    logic [3:0]  flags;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // char_code
  logic        s_axis_tuser = 1'b0; // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // value
  logic [3:0]  m_axis_tuser;        // empty_pop_seen, stack_full_seen, div_zero_seen,
                                    // saturated_seen

  answer_t     answers_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  // calculator state mirrored by the predictor
  logic [63:0] stk [Depth];
  int unsigned depth_used;
  bit          num_on;
  bit          frac_on;
  logic [63:0] mant;
  int unsigned frac_digits;
  logic [3:0]  seen;

  always #1 clk_i = ~clk_i;

  rpn_stack_calculator_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function void calc_clear();
    depth_used = 0;
    num_on = 0;
    frac_on = 0;
    mant = '0;
    frac_digits = 0;
    seen = '0;
  endfunction

  function void stack_push(input logic [63:0] v);
    if (depth_used >= Depth) begin
      seen[FlagFull] = 1'b1;
    end else begin
      stk[depth_used] = v;
      depth_used++;
    end
  endfunction

  function logic [63:0] stack_pop();
    if (depth_used == 0) begin
      seen[FlagEmpty] = 1'b1;
      return '0;
    end
    depth_used--;
    return stk[depth_used];
  endfunction

  function logic [63:0] abs64(input logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function logic [63:0] clamp_signed(input bit neg, input logic [127:0] mag);
    if (neg) begin
      if (mag > {64'd0, NegMin}) begin
        seen[FlagSat] = 1'b1;
        return NegMin;
      end
      return -mag[63:0];
    end
    if (mag > {64'd0, PosMax}) begin
      seen[FlagSat] = 1'b1;
      return PosMax;
    end
    return mag[63:0];
  endfunction

  function logic [63:0] arith(input logic [7:0] op, input logic [63:0] a, input logic [63:0] b);
    logic [63:0]  r;
    logic [127:0] wide;
    bit           neg;
    neg = a[63] ^ b[63];
    case (op)
      ChPlus: begin
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
          seen[FlagSat] = 1'b1;
          r = a[63] ? NegMin : PosMax;
        end
      end
      ChMinus: begin
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
          seen[FlagSat] = 1'b1;
          r = a[63] ? NegMin : PosMax;
        end
      end
      ChStar: begin
        wide = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        r = clamp_signed(neg, wide >> FracBits);
      end
      default: begin
        if (b == 0) begin
          seen[FlagDivz] = 1'b1;
          r = a[63] ? NegMin : PosMax;
        end else begin
          wide = ({64'd0, abs64(a)} << FracBits) / {64'd0, abs64(b)};
          r = clamp_signed(neg, wide);
        end
      end
    endcase
    return r;
  endfunction

  function void close_number();
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] frac;
    logic [63:0] v;
    d = 64'd1;
    for (int i = 0; i < frac_digits; i++) d = d * 64'd10;
    q = mant / d;
    rem = mant % d;
    frac = '0;
    for (int i = 0; i < FracBits; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= d) begin
        rem = rem - d;
        frac[0] = 1'b1;
      end
    end
    if ((rem << 1) >= d) frac = frac + 1;
    if (q >= (64'd1 << (63 - FracBits))) begin
      seen[FlagSat] = 1'b1;
      v = PosMax;
    end else begin
      v = (q << FracBits) + frac;
      if (v > PosMax) begin
        seen[FlagSat] = 1'b1;
        v = PosMax;
      end
    end
    stack_push(v);
    num_on = 0;
    frac_on = 0;
    mant = '0;
    frac_digits = 0;
  endfunction

  function void take_digit(input logic [7:0] c);
    logic [63:0] dg;
    dg = {56'd0, c - ChZero};
    if (mant > (64'hffff_ffff_ffff_ffff - dg) / 10) begin
      mant = 64'hffff_ffff_ffff_ffff;
      seen[FlagSat] = 1'b1;
    end else begin
      mant = mant * 10 + dg;
    end
  endfunction

  // returns 1 when the transaction produces an answer
  function bit calc_step(input logic [7:0] c, input logic eoi, output answer_t ans);
    bit          digit;
    logic [63:0] a;
    logic [63:0] b;
    digit = (c >= ChZero && c <= ChNine);
    if (eoi) begin
      if (num_on) close_number();
      ans.value = stack_pop();
      ans.flags = seen;
      calc_clear();
      return 1;
    end
    if (num_on) begin
      if (digit) begin
        if (!frac_on) begin
          take_digit(c);
        end else if (frac_digits < MaxDigits) begin
          take_digit(c);
          frac_digits++;
        end
        return 0;
      end
      if (c == ChPoint && !frac_on) begin
        frac_on = 1;
        return 0;
      end
      close_number();
    end
    if (digit) begin
      num_on = 1;
      take_digit(c);
    end else if (c == ChPoint) begin
      num_on = 1;
      frac_on = 1;
    end else if (c == ChPlus || c == ChMinus || c == ChStar || c == ChSlash) begin
      b = stack_pop();
      a = stack_pop();
      stack_push(arith(c, a, b));
    end
    return 0;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eoi, input bit typed,
                           input answer_t typed_ans);
    answer_t ans;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (calc_step(c, eoi, ans)) answers_due.push_back(typed ? typed_ans : ans);
  endtask

  task automatic send_plain(input logic [7:0] c, input logic eoi);
    answer_t none;
    none = '{default: '0};
    send_char(c, eoi, 0, none);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_number(input bit full_range);
    int unsigned n_int;
    int unsigned n_frac;
    n_int = full_range ? $urandom_range(0, 24) : $urandom_range(0, 4);
    for (int i = 0; i < n_int; i++) send_plain(ChZero + 8'($urandom_range(9)), 1'b0);
    if (n_int == 0 || $urandom_range(1)) begin
      send_plain(ChPoint, 1'b0);
      n_frac = $urandom_range(0, 12);
      for (int i = 0; i < n_frac; i++) send_plain(ChZero + 8'($urandom_range(9)), 1'b0);
      if ($urandom_range(19) == 0) send_plain(ChPoint, 1'b0);
    end
    if ($urandom_range(3) != 0) send_plain($urandom_range(1) ? ChSpace : ChTab, 1'b0);
  endtask

  task automatic send_expression();
    int unsigned steps;
    int unsigned live;
    logic [7:0]  ops [4];
    ops = '{ChPlus, ChMinus, ChStar, ChSlash};
    steps = $urandom_range(1, 9);
    live = 0;
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(9) == 0) begin
        send_plain(8'($urandom_range(255)), 1'b0);
      end else if (live < 2 && $urandom_range(7) != 0 || $urandom_range(2) == 0) begin
        send_number($urandom_range(9) == 0);
        live++;
      end else begin
        send_plain(ops[$urandom_range(3)], 1'b0);
        if (live > 0) live--;
      end
    end
    if ($urandom_range(4) == 0) send_plain(ops[$urandom_range(3)], 1'b0);
    send_plain(8'($urandom_range(255)), 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch($sformatf("value %h, want %h", m_axis_tdata, want.value));
        if (m_axis_tuser !== want.flags)
          report_mismatch($sformatf("flags %b, want %b", m_axis_tuser, want.flags));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    row_t        rows [$];
    answer_t     typed_ans;
    int unsigned phase;
    calc_clear();
    rows = '{
      '{8'h00, 1'b1, 1, 64'd0, 4'b0001},
      '{"3", 1'b0, 0, '0, '0}, '{ChSpace, 1'b0, 0, '0, '0}, '{"4", 1'b0, 0, '0, '0},
      '{ChPlus, 1'b0, 0, '0, '0}, '{8'hff, 1'b1, 1, 64'h7_0000, 4'b0000},
      '{"1", 1'b0, 0, '0, '0}, '{ChSpace, 1'b0, 0, '0, '0}, '{"0", 1'b0, 0, '0, '0},
      '{ChSlash, 1'b0, 0, '0, '0}, '{8'h00, 1'b1, 1, PosMax, 4'b0100},
      '{ChMinus, 1'b0, 0, '0, '0}, '{8'h00, 1'b1, 1, 64'd0, 4'b0001},
      '{"2", 1'b0, 0, '0, '0}, '{ChPoint, 1'b0, 0, '0, '0}, '{"5", 1'b0, 0, '0, '0},
      '{ChSpace, 1'b0, 0, '0, '0}, '{ChPoint, 1'b0, 0, '0, '0}, '{"5", 1'b0, 0, '0, '0},
      '{ChStar, 1'b0, 0, '0, '0}, '{8'h80, 1'b1, 0, '0, '0},
      '{ChTab, 1'b0, 0, '0, '0}, '{"x", 1'b0, 0, '0, '0}, '{"9", 1'b0, 0, '0, '0},
      '{8'h00, 1'b1, 1, 64'h9_0000, 4'b0000}
    };
    send_idle_pct = 11;
    recv_idle_pct = 70;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      typed_ans.value = rows[i].value;
      typed_ans.flags = rows[i].flags;
      send_char(rows[i].ch, rows[i].eoi, rows[i].typed, typed_ans);
    end

    // overfill the stack, then add the top two entries and end the input
    for (int i = 0; i < Depth + 3; i++) begin
      send_plain("1", 1'b0);
      send_plain(ChSpace, 1'b0);
    end
    send_plain(ChPlus, 1'b0);
    send_plain(8'h00, 1'b1);

    phase = 0;
    while (items_sent < TotalItems) begin
      if (phase == 0 && items_sent >= TotalItems / 3) begin
        drain();
        send_idle_pct = 70;
        recv_idle_pct = 11;
        phase = 1;
      end else if (phase == 1 && items_sent >= 2 * TotalItems / 3) begin
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        phase = 2;
      end
      send_expression();
    end
    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
